### design/ers_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables for the euler rotate to spherical block
// depends on nothing; imported by ers_vec_cordic, euler_rotate_to_spherical and the testbench
package ers_pkg;

	localparam int PW        = 32;
	localparam int ANG_ACC_W = 34;
	localparam int CS_W      = 34;
	localparam int TRIG_W    = 28;
	localparam int ACC_W     = 30;
	localparam int MAT_W     = 16;

	localparam logic signed [CS_W-1:0]      KINV_Q30     = 34'sd652032874;
	localparam logic signed [ANG_ACC_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [MAT_W-1:0]     MAT_ONE      = 16'sd16384;

	localparam logic [1:0] REG_ROLL    = 2'd0;
	localparam logic [1:0] REG_PITCH   = 2'd1;
	localparam logic [1:0] REG_HEADING = 2'd2;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
		32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
	};

	typedef enum logic [2:0] {
		OP_SR, OP_CR, OP_SP, OP_CP, OP_SH, OP_CH, OP_T0, OP_T1
	} op_t;

	typedef enum logic [2:0] {
		MD_T0, MD_T1, MD_PUT, MD_LOAD, MD_ADD, MD_SUB
	} mode_t;

	typedef struct packed {
		op_t        opa;
		op_t        opb;
		mode_t      mode;
		logic [3:0] dst;
	} step_t;

	localparam logic [3:0] STEP_LAST = 4'd13;

	// product schedule for the matrix rebuild
	function automatic step_t step_info(input logic [3:0] step);
		step_t s;
		unique case (step)
			4'd0:    s = '{OP_SP, OP_SR, MD_T0,   4'd0};
			4'd1:    s = '{OP_SP, OP_CR, MD_T1,   4'd0};
			4'd2:    s = '{OP_CH, OP_CP, MD_PUT,  4'd0};
			4'd3:    s = '{OP_CH, OP_T0, MD_LOAD, 4'd0};
			4'd4:    s = '{OP_SH, OP_CR, MD_SUB,  4'd1};
			4'd5:    s = '{OP_CH, OP_T1, MD_LOAD, 4'd0};
			4'd6:    s = '{OP_SH, OP_SR, MD_ADD,  4'd2};
			4'd7:    s = '{OP_SH, OP_CP, MD_PUT,  4'd3};
			4'd8:    s = '{OP_SH, OP_T0, MD_LOAD, 4'd0};
			4'd9:    s = '{OP_CH, OP_CR, MD_ADD,  4'd4};
			4'd10:   s = '{OP_SH, OP_T1, MD_LOAD, 4'd0};
			4'd11:   s = '{OP_CH, OP_SR, MD_SUB,  4'd5};
			4'd12:   s = '{OP_CP, OP_SR, MD_PUT,  4'd7};
			4'd13:   s = '{OP_CP, OP_CR, MD_PUT,  4'd8};
			default: s = '{OP_SR, OP_SR, MD_T0,   4'd0};
		endcase
		return s;
	endfunction

	// q24 value to q1.14 matrix entry, rounded half up and saturated
	function automatic logic signed [MAT_W-1:0] to_entry(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + 30'sd512) >>> 10;
		if (r > 30'sd16384)
			return MAT_ONE;
		else if (r < -30'sd16384)
			return -MAT_ONE;
		else
			return r[MAT_W-1:0];
	endfunction

endpackage

### design/ers_vec_cordic.sv
`timescale 1ns / 1ps
// pipelined vectoring cordic: angle of (x, y) in 2^32 units per turn
// depends on ers_pkg for the arctangent table and angle width
module ers_vec_cordic #(
	parameter int IW     = 33,
	parameter int STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [IW-1:0]                 x,
	input  logic signed [IW-1:0]                 y,
	output logic signed [ers_pkg::ANG_ACC_W-1:0] angle
);
	import ers_pkg::*;

	localparam int W = IW + 3;

	logic signed [W-1:0]         x_sn [0:STAGES];
	logic signed [W-1:0]         y_sn [0:STAGES];
	logic signed [ANG_ACC_W-1:0] a_sn [0:STAGES];

	logic signed [W-1:0]         x_nx [0:STAGES];
	logic signed [W-1:0]         y_nx [0:STAGES];
	logic signed [ANG_ACC_W-1:0] a_nx [0:STAGES];

	logic signed [W-1:0] xw, yw;

	assign xw = W'(x);
	assign yw = W'(y);

	always_comb begin
		// quadrant fold into the right half plane
		if (xw < 0) begin
			if (yw >= 0) begin
				x_nx[0] = yw;
				y_nx[0] = -xw;
				a_nx[0] = QUARTER_TURN;
			end else begin
				x_nx[0] = -yw;
				y_nx[0] = xw;
				a_nx[0] = -QUARTER_TURN;
			end
		end else begin
			x_nx[0] = xw;
			y_nx[0] = yw;
			a_nx[0] = '0;
		end
		for (int i = 1; i <= STAGES; i++) begin
			if (y_sn[i-1] > 0) begin
				x_nx[i] = x_sn[i-1] + (y_sn[i-1] >>> (i - 1));
				y_nx[i] = y_sn[i-1] - (x_sn[i-1] >>> (i - 1));
				a_nx[i] = a_sn[i-1] + $signed(ANG_ACC_W'(ATAN_TAB[i-1]));
			end else begin
				x_nx[i] = x_sn[i-1] - (y_sn[i-1] >>> (i - 1));
				y_nx[i] = y_sn[i-1] + (x_sn[i-1] >>> (i - 1));
				a_nx[i] = a_sn[i-1] - $signed(ANG_ACC_W'(ATAN_TAB[i-1]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i <= STAGES; i++) begin
				x_sn[i] <= x_nx[i];
				y_sn[i] <= y_nx[i];
				a_sn[i] <= a_nx[i];
			end
		end
	end

	assign angle = a_sn[STAGES];

endmodule

### design/euler_rotate_to_spherical.sv
`timescale 1ns / 1ps
// top level: euler zyx rotation of a direction vector and conversion to spherical angles
// depends on ers_pkg and ers_vec_cordic
//
// One vector (x_in, y_in, z_in) is taken per cycle while vec_stall is low
// and gives one result beat (polar_angle, azimuth, zero_vector) through
// matrix multiply, magnitude and a 32-stage square root pipeline, then two
// vectoring cordic pipelines of CORDIC_STAGES + 1 stages, then a two-entry
// output queue. Writing an angle register rebuilds the matrix with one
// iterative sin/cos cordic and one shared multiplier; vec_stall is held high
// while the rebuild runs.
module euler_rotate_to_spherical #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           vec_valid,
	output logic                           vec_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in,
	input  logic signed [SAMPLE_WIDTH-1:0] y_in,
	input  logic signed [SAMPLE_WIDTH-1:0] z_in,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [ANGLE_WIDTH-1:0]         polar_angle,
	output logic signed [ANGLE_WIDTH-1:0]  azimuth,
	output logic                           zero_vector
);
	import ers_pkg::*;

	localparam int PRW  = SAMPLE_WIDTH + MAT_W;
	localparam int SUMW = SAMPLE_WIDTH + 18;
	localparam int DN   = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH - 16 : 0;
	localparam int UP   = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
	localparam int ITW  = $clog2(CORDIC_STAGES + 1);
	localparam int SH   = 32 - ANGLE_WIDTH;
	localparam int RW   = ANG_ACC_W + 1;
	localparam logic signed [RW-1:0] HALF = RW'((64'd1 << SH) >> 1);
	localparam logic signed [RW-1:0] LIM  = RW'(64'd1 << (ANGLE_WIDTH - 1));
	localparam int NSQ  = 32;

	// ---------------- configuration registers ----------------

	logic [ANGLE_WIDTH-1:0] roll_q, pitch_q, heading_q;
	logic                   cfg_wr;
	logic [1:0]             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		unique case (cfg_idx)
			REG_ROLL:    prdata = 32'(roll_q);
			REG_PITCH:   prdata = 32'(pitch_q);
			REG_HEADING: prdata = 32'(heading_q);
			default:     prdata = '0;
		endcase
	end

	// ---------------- matrix rebuild sequencer ----------------

	typedef enum logic [2:0] {B_IDLE, B_LOAD, B_ROT, B_STORE, B_MUL, B_ACC} bst_t;

	bst_t                     bst_q;
	logic [1:0]               ang_q;
	logic [ITW-1:0]           it_q;
	logic signed [CS_W-1:0]   cx_q, cy_q, cz_q;
	logic [1:0]               quad_q;
	logic [3:0]               step_q;
	logic signed [55:0]       prod_q;
	logic signed [TRIG_W-1:0] acc_q, t0_q, t1_q;
	logic signed [TRIG_W-1:0] c_q [3];
	logic signed [TRIG_W-1:0] s_q [3];
	logic signed [MAT_W-1:0]  mat_q [9];

	logic [ANGLE_WIDTH-1:0]   ang_sel;
	logic [31:0]              a32, z32;
	logic [1:0]               quad;
	logic [4:0]               k;
	logic signed [CS_W-1:0]   atk, cc, ss;
	step_t                    st;
	logic signed [TRIG_W-1:0] opa, opb, prnd;
	logic signed [55:0]       prnd_w;
	logic signed [ACC_W-1:0]  acc_add, acc_sub;
	logic                     busy;

	assign busy = (bst_q != B_IDLE);

	always_comb begin
		unique case (ang_q)
			REG_ROLL:    ang_sel = roll_q;
			REG_PITCH:   ang_sel = pitch_q;
			default:     ang_sel = heading_q;
		endcase
		a32  = 32'(ang_sel) << SH;
		quad = 2'((a32 + 32'h2000_0000) >> 30);
		z32  = a32 - {quad, 30'd0};
		k    = 5'(it_q);
		atk  = $signed(CS_W'(ATAN_TAB[k]));
		case (quad_q)
			2'd1:    begin cc = -cy_q; ss = cx_q;  end
			2'd2:    begin cc = -cx_q; ss = -cy_q; end
			2'd3:    begin cc = cy_q;  ss = -cx_q; end
			default: begin cc = cx_q;  ss = cy_q;  end
		endcase
		st = step_info(step_q);
		case (st.opa)
			OP_SR:   opa = s_q[0];
			OP_CR:   opa = c_q[0];
			OP_SP:   opa = s_q[1];
			OP_CP:   opa = c_q[1];
			OP_SH:   opa = s_q[2];
			OP_CH:   opa = c_q[2];
			OP_T0:   opa = t0_q;
			default: opa = t1_q;
		endcase
		case (st.opb)
			OP_SR:   opb = s_q[0];
			OP_CR:   opb = c_q[0];
			OP_SP:   opb = s_q[1];
			OP_CP:   opb = c_q[1];
			OP_SH:   opb = s_q[2];
			OP_CH:   opb = c_q[2];
			OP_T0:   opb = t0_q;
			default: opb = t1_q;
		endcase
		prnd_w  = (prod_q + 56'sd8388608) >>> 24;
		prnd    = prnd_w[TRIG_W-1:0];
		acc_add = ACC_W'(acc_q) + ACC_W'(prnd);
		acc_sub = ACC_W'(acc_q) - ACC_W'(prnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q     <= B_IDLE;
			roll_q    <= '0;
			pitch_q   <= '0;
			heading_q <= '0;
			ang_q     <= '0;
			it_q      <= '0;
			step_q    <= '0;
			quad_q    <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
			prod_q    <= '0;
			acc_q     <= '0;
			t0_q      <= '0;
			t1_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				c_q[i] <= '0;
				s_q[i] <= '0;
			end
			for (int i = 0; i < 9; i++)
				mat_q[i] <= (i % 4 == 0) ? MAT_ONE : '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_ROLL:    roll_q    <= pwdata[ANGLE_WIDTH-1:0];
					REG_PITCH:   pitch_q   <= pwdata[ANGLE_WIDTH-1:0];
					REG_HEADING: heading_q <= pwdata[ANGLE_WIDTH-1:0];
					default:     ;
				endcase
				if (cfg_idx != 2'd3) begin
					bst_q <= B_LOAD;
					ang_q <= '0;
				end
			end else begin
				unique case (bst_q)
					B_IDLE: ;
					B_LOAD: begin
						cx_q   <= KINV_Q30;
						cy_q   <= '0;
						cz_q   <= CS_W'($signed(z32));
						quad_q <= quad;
						it_q   <= '0;
						bst_q  <= B_ROT;
					end
					B_ROT: begin
						if (cz_q >= 0) begin
							cx_q <= cx_q - (cy_q >>> k);
							cy_q <= cy_q + (cx_q >>> k);
							cz_q <= cz_q - atk;
						end else begin
							cx_q <= cx_q + (cy_q >>> k);
							cy_q <= cy_q - (cx_q >>> k);
							cz_q <= cz_q + atk;
						end
						it_q <= it_q + 1'b1;
						if (it_q == ITW'(CORDIC_STAGES - 1))
							bst_q <= B_STORE;
					end
					B_STORE: begin
						c_q[ang_q] <= TRIG_W'((cc + 34'sd32) >>> 6);
						s_q[ang_q] <= TRIG_W'((ss + 34'sd32) >>> 6);
						if (ang_q == REG_HEADING) begin
							step_q <= '0;
							bst_q  <= B_MUL;
						end else begin
							ang_q <= ang_q + 1'b1;
							bst_q <= B_LOAD;
						end
					end
					B_MUL: begin
						prod_q <= opa * opb;
						bst_q  <= B_ACC;
					end
					B_ACC: begin
						case (st.mode)
							MD_T0:   t0_q <= prnd;
							MD_T1:   t1_q <= prnd;
							MD_LOAD: acc_q <= prnd;
							MD_ADD:  mat_q[st.dst] <= to_entry(acc_add);
							MD_SUB:  mat_q[st.dst] <= to_entry(acc_sub);
							default: mat_q[st.dst] <= to_entry(ACC_W'(prnd));
						endcase
						if (step_q == STEP_LAST) begin
							mat_q[6] <= to_entry(-ACC_W'(s_q[1]));
							bst_q    <= B_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
							bst_q  <= B_MUL;
						end
					end
					default: bst_q <= B_IDLE;
				endcase
			end
		end
	end

	// ---------------- vector pipeline ----------------

	logic [1:0] cnt_q;
	logic       adv, acc_in;

	assign adv       = (cnt_q != 2'd2);
	assign vec_stall = !adv || busy;
	assign acc_in    = vec_valid && !vec_stall;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PRW-1:0] prod_s1 [9];
	logic signed [PW-1:0]  p_s2 [3];
	logic signed [PW-1:0]  p_s3 [3];
	logic signed [PW-1:0]  p_s4 [3];
	logic signed [PW-1:0]  p_s5 [3];
	logic [30:0]           mag0_s3, mag1_s3;
	logic [61:0]           sq0_s4, sq1_s4;
	logic [62:0]           rad_s5;
	logic                  z_s3, z_s4, z_s5;

	logic signed [SUMW-1:0]    rsum [3];
	logic signed [SUMW+15:0]   rext [3];
	logic signed [PW-1:0]      pnx [3];
	logic signed [PW-1:0]      negp0, negp1;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rsum[r] = SUMW'(prod_s1[3*r]) + SUMW'(prod_s1[3*r+1]) + SUMW'(prod_s1[3*r+2]);
			rext[r] = (SUMW+16)'(rsum[r]);
			if (SAMPLE_WIDTH > 16)
				pnx[r] = PW'(rext[r] >>> DN);
			else
				pnx[r] = PW'(rext[r] <<< UP);
		end
		negp0 = -p_s2[0];
		negp1 = -p_s2[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= mat_q[3*r]   * x_in;
				prod_s1[3*r+1] <= mat_q[3*r+1] * y_in;
				prod_s1[3*r+2] <= mat_q[3*r+2] * z_in;
				p_s2[r] <= pnx[r];
				p_s3[r] <= p_s2[r];
				p_s4[r] <= p_s3[r];
				p_s5[r] <= p_s4[r];
			end
			z_s3    <= (p_s2[0] == 0) && (p_s2[1] == 0) && (p_s2[2] == 0);
			mag0_s3 <= p_s2[0][PW-1] ? negp0[30:0] : p_s2[0][30:0];
			mag1_s3 <= p_s2[1][PW-1] ? negp1[30:0] : p_s2[1][30:0];
			sq0_s4  <= mag0_s3 * mag0_s3;
			sq1_s4  <= mag1_s3 * mag1_s3;
			z_s4    <= z_s3;
			rad_s5  <= 63'(sq0_s4) + 63'(sq1_s4);
			z_s5    <= z_s4;
		end
	end

	// square root, one result bit per stage

	logic [62:0]          rem_sn  [NSQ];
	logic [63:0]          root_sn [NSQ];
	logic signed [PW-1:0] sp_sn   [NSQ][3];
	logic                 sv_sn   [NSQ];
	logic                 sz_sn   [NSQ];

	logic [62:0]          rem_in  [NSQ];
	logic [63:0]          root_in [NSQ];
	logic [62:0]          rem_nx  [NSQ];
	logic [63:0]          root_nx [NSQ];
	logic [63:0]          trial   [NSQ];
	logic [63:0]          bitv    [NSQ];

	always_comb begin
		rem_in[0]  = rad_s5;
		root_in[0] = '0;
		for (int j = 1; j < NSQ; j++) begin
			rem_in[j]  = rem_sn[j-1];
			root_in[j] = root_sn[j-1];
		end
		for (int j = 0; j < NSQ; j++) begin
			bitv[j]  = 64'd1 << (62 - 2 * j);
			trial[j] = root_in[j] + bitv[j];
			if ({1'b0, rem_in[j]} >= trial[j]) begin
				rem_nx[j]  = rem_in[j] - trial[j][62:0];
				root_nx[j] = (root_in[j] >> 1) + bitv[j];
			end else begin
				rem_nx[j]  = rem_in[j];
				root_nx[j] = root_in[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NSQ; j++)
				sv_sn[j] <= 1'b0;
		end else if (adv) begin
			sv_sn[0] <= v_s5;
			for (int j = 1; j < NSQ; j++)
				sv_sn[j] <= sv_sn[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NSQ; j++) begin
				rem_sn[j]  <= rem_nx[j];
				root_sn[j] <= root_nx[j];
			end
			sz_sn[0] <= z_s5;
			for (int r = 0; r < 3; r++)
				sp_sn[0][r] <= p_s5[r];
			for (int j = 1; j < NSQ; j++) begin
				sz_sn[j] <= sz_sn[j-1];
				for (int r = 0; r < 3; r++)
					sp_sn[j][r] <= sp_sn[j-1][r];
			end
		end
	end

	// angle cordics

	logic signed [PW:0]          az_x, az_y, pol_x, pol_y;
	logic signed [ANG_ACC_W-1:0] az_ang, pol_ang;
	logic                        cv_sn [0:CORDIC_STAGES];
	logic                        cz_sn [0:CORDIC_STAGES];

	assign az_x  = (PW+1)'(sp_sn[NSQ-1][0]);
	assign az_y  = (PW+1)'(sp_sn[NSQ-1][1]);
	assign pol_x = (PW+1)'(sp_sn[NSQ-1][2]);
	assign pol_y = $signed({1'b0, root_sn[NSQ-1][31:0]});

	ers_vec_cordic #(
		.IW     (PW + 1),
		.STAGES (CORDIC_STAGES)
	) u_az_cordic (
		.clk   (clk),
		.en    (adv),
		.x     (az_x),
		.y     (az_y),
		.angle (az_ang)
	);

	ers_vec_cordic #(
		.IW     (PW + 1),
		.STAGES (CORDIC_STAGES)
	) u_pol_cordic (
		.clk   (clk),
		.en    (adv),
		.x     (pol_x),
		.y     (pol_y),
		.angle (pol_ang)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CORDIC_STAGES; i++)
				cv_sn[i] <= 1'b0;
		end else if (adv) begin
			cv_sn[0] <= sv_sn[NSQ-1];
			for (int i = 1; i <= CORDIC_STAGES; i++)
				cv_sn[i] <= cv_sn[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cz_sn[0] <= sz_sn[NSQ-1];
			for (int i = 1; i <= CORDIC_STAGES; i++)
				cz_sn[i] <= cz_sn[i-1];
		end
	end

	// rounding, clamp and zero handling

	logic signed [RW-1:0]         az_r, pol_r;
	logic [ANGLE_WIDTH-1:0]       pol_d;
	logic signed [ANGLE_WIDTH-1:0] az_d;
	logic                          zv_d;

	always_comb begin
		az_r  = (RW'(az_ang) + HALF) >>> SH;
		pol_r = (RW'(pol_ang) + HALF) >>> SH;
		if (pol_r < 0)
			pol_r = '0;
		else if (pol_r > LIM)
			pol_r = LIM;
		zv_d = cz_sn[CORDIC_STAGES];
		if (zv_d) begin
			pol_d = '0;
			az_d  = '0;
		end else begin
			pol_d = pol_r[ANGLE_WIDTH-1:0];
			az_d  = az_r[ANGLE_WIDTH-1:0];
		end
	end

	// ---------------- two-entry result queue ----------------

	logic                          push, pop;
	logic [ANGLE_WIDTH-1:0]        pol0_q, pol1_q;
	logic signed [ANGLE_WIDTH-1:0] az0_q, az1_q;
	logic                          zv0_q, zv1_q;

	assign push = adv && cv_sn[CORDIC_STAGES];
	assign pop  = res_valid && !res_stall;

	assign res_valid   = (cnt_q != 2'd0);
	assign polar_angle = pol0_q;
	assign azimuth     = az0_q;
	assign zero_vector = zv0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					pol0_q <= pol_d;
					az0_q  <= az_d;
					zv0_q  <= zv_d;
				end else begin
					pol1_q <= pol_d;
					az1_q  <= az_d;
					zv1_q  <= zv_d;
				end
			end
			2'b01: begin
				pol0_q <= pol1_q;
				az0_q  <= az1_q;
				zv0_q  <= zv1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					pol0_q <= pol_d;
					az0_q  <= az_d;
					zv0_q  <= zv_d;
				end else begin
					pol0_q <= pol1_q;
					az0_q  <= az1_q;
					zv0_q  <= zv1_q;
					pol1_q <= pol_d;
					az1_q  <= az_d;
					zv1_q  <= zv_d;
				end
			end
			default: ;
		endcase
	end

endmodule

### test/tb_euler_rotate_to_spherical.sv
`timescale 1ns / 1ps
// testbench for euler_rotate_to_spherical: directed vectors, then random vectors under angle sweeps
// depends on ers_pkg and the block; results are checked against a bit-exact predictor held here
module tb_euler_rotate_to_spherical;
	import ers_pkg::*;

	typedef struct {
		logic [15:0]        pol;
		logic signed [15:0] az;
		logic               zv;
	} sph_t;

	typedef struct {
		logic signed [15:0] x, y, z;
		bit                 known;
		sph_t               want;
	} dir_row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               vec_valid = 0;
	logic               vec_stall;
	logic signed [15:0] x_in = '0, y_in = '0, z_in = '0;
	logic               res_valid;
	logic               res_stall = 0;
	logic [15:0]        polar_angle;
	logic signed [15:0] azimuth;
	logic               zero_vector;

	sph_t        pending_dirs[$];
	int          fails = 0;
	int          send_idle = 0, rcv_idle = 0;
	int          hold_left = 0;
	logic [15:0] roll_q, pitch_q, heading_q;
	longint      rot_mat[9];

	localparam longint ARCTAN[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41721, 20860};

	euler_rotate_to_spherical DUT (.*);

	always #6 clk = ~clk;

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic void sin_cos_of(input logic [15:0] ang, output longint c, output longint s);
		longint a, q, z, x, y, nx, ny, cc, ss;
		a = longint'({ang, 16'h0});
		q = ((a + 64'h2000_0000) >> 30) & 3;
		z = (a - q * 64'h4000_0000) & 64'hFFFF_FFFF;
		if (z >= 64'h8000_0000)
			z -= 64'h1_0000_0000;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
			end
			x = nx; y = ny;
		end
		case (q)
			1: begin cc = -y; ss = x; end
			2: begin cc = -x; ss = -y; end
			3: begin cc = y; ss = -x; end
			default: begin cc = x; ss = y; end
		endcase
		c = round_shift(cc, 6);
		s = round_shift(ss, 6);
	endfunction

	function automatic longint mul_q24(longint a, longint b);
		return round_shift(a * b, 24);
	endfunction

	function automatic longint q24_to_entry(longint v);
		longint r;
		r = round_shift(v, 10);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	function automatic void rebuild_matrix();
		longint cr, sr, cp, sp, ch, sh, spsr, spcr;
		sin_cos_of(roll_q, cr, sr);
		sin_cos_of(pitch_q, cp, sp);
		sin_cos_of(heading_q, ch, sh);
		spsr = mul_q24(sp, sr);
		spcr = mul_q24(sp, cr);
		rot_mat[0] = q24_to_entry(mul_q24(ch, cp));
		rot_mat[1] = q24_to_entry(mul_q24(ch, spsr) - mul_q24(sh, cr));
		rot_mat[2] = q24_to_entry(mul_q24(ch, spcr) + mul_q24(sh, sr));
		rot_mat[3] = q24_to_entry(mul_q24(sh, cp));
		rot_mat[4] = q24_to_entry(mul_q24(sh, spsr) + mul_q24(ch, cr));
		rot_mat[5] = q24_to_entry(mul_q24(sh, spcr) - mul_q24(ch, sr));
		rot_mat[6] = q24_to_entry(-sp);
		rot_mat[7] = q24_to_entry(mul_q24(cp, sr));
		rot_mat[8] = q24_to_entry(mul_q24(cp, cr));
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'h4000_0000_0000_0000;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint a, t, nx, ny;
		a = 0;
		if (x < 0) begin
			if (y >= 0) begin t = x; x = y; y = -t; a = 64'sd1073741824; end
			else begin t = x; x = -y; y = t; a = -64'sd1073741824; end
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); a += ARCTAN[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); a -= ARCTAN[i];
			end
			x = nx; y = ny;
		end
		return a;
	endfunction

	function automatic sph_t rotate_to_spherical(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		longint v[3], p[3], az, pol;
		longint unsigned rho;
		sph_t r;
		v[0] = x; v[1] = y; v[2] = z;
		for (int i = 0; i < 3; i++)
			p[i] = rot_mat[3*i] * v[0] + rot_mat[3*i+1] * v[1] + rot_mat[3*i+2] * v[2];
		if (p[0] == 0 && p[1] == 0 && p[2] == 0) begin
			r.pol = 0; r.az = 0; r.zv = 1;
			return r;
		end
		az = round_shift(vector_angle(p[1], p[0]), 16);
		rho = floor_sqrt(longint'(p[0] * p[0]) + longint'(p[1] * p[1]));
		pol = round_shift(vector_angle(longint'(rho), p[2]), 16);
		if (pol < 0) pol = 0;
		if (pol > 32768) pol = 32768;
		r.pol = pol[15:0];
		r.az = az[15:0];
		r.zv = 0;
		return r;
	endfunction

	task automatic apb_write(logic [3:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (addr[3:2])
			REG_ROLL:    roll_q = val[15:0];
			REG_PITCH:   pitch_q = val[15:0];
			REG_HEADING: heading_q = val[15:0];
			default:     return;
		endcase
		rebuild_matrix();
	endtask

	task automatic set_angles(logic [15:0] r, logic [15:0] p, logic [15:0] h);
		vec_valid <= 0;
		while (pending_dirs.size() != 0) @(posedge clk);
		apb_write({REG_ROLL, 2'b00}, {16'($urandom_range(65535)), r});
		apb_write({REG_PITCH, 2'b00}, {16'($urandom_range(65535)), p});
		apb_write({REG_HEADING, 2'b00}, {16'($urandom_range(65535)), h});
	endtask

	task automatic send_dir(dir_row_t row);
		bit took;
		if ($urandom_range(99) < send_idle) begin
			vec_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		vec_valid <= 1;
		x_in <= row.x; y_in <= row.y; z_in <= row.z;
		do begin
			@(negedge clk);
			took = !vec_stall;
			@(posedge clk);
		end while (!took);
		pending_dirs.push_back(row.known ? row.want : rotate_to_spherical(row.x, row.y, row.z));
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(5))
			0:       return 16'($signed($urandom_range(512)) - 256);
			1:       return 0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_dirs(int n);
		dir_row_t row;
		row.known = 0;
		for (int i = 0; i < n; i++) begin
			row.x = rand_comp(); row.y = rand_comp(); row.z = rand_comp();
			if ($urandom_range(49) == 0) begin
				row.x = 0; row.y = 0; row.z = 0;
			end
			send_dir(row);
		end
	endtask

	// receiver side, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	always @(negedge clk) begin
		sph_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_dirs.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				e = pending_dirs.pop_front();
				if (polar_angle !== e.pol) begin
					$error("polar_angle exp %0d got %0d", e.pol, polar_angle);
					fails++;
				end
				if (azimuth !== e.az) begin
					$error("azimuth exp %0d got %0d", e.az, azimuth);
					fails++;
				end
				if (zero_vector !== e.zv) begin
					$error("zero_vector exp %0d got %0d", e.zv, zero_vector);
					fails++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t row;
		sph_t zero_res;
		int idle_plan[3][2] = '{'{21, 78}, '{78, 21}, '{0, 0}};
		logic [15:0] sweep[8][3] = '{'{0, 0, 0}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{16'h4000, 0, 0}, '{0, 16'h8000, 0}, '{0, 0, 16'hC000},
			'{16'h2000, 16'hE000, 16'h7FFF}, '{0, 0, 0}, '{0, 0, 0}};

		zero_res = '{pol: 16'd0, az: 16'sd0, zv: 1'b1};
		roll_q = 0; pitch_q = 0; heading_q = 0;
		for (int i = 0; i < 9; i++)
			rot_mat[i] = (i % 4 == 0) ? 16384 : 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed vectors at reset, identity matrix
		row.known = 1; row.want = zero_res;
		row.x = 0; row.y = 0; row.z = 0; dir_rows.push_back(row);
		row.known = 0;
		row.x = 16384; row.y = 0; row.z = 0; dir_rows.push_back(row);
		row.x = -16384; row.y = 0; row.z = 0; dir_rows.push_back(row);
		row.x = 0; row.y = 16384; row.z = 0; dir_rows.push_back(row);
		row.x = 0; row.y = -16384; row.z = 0; dir_rows.push_back(row);
		row.x = 0; row.y = 0; row.z = 16384; dir_rows.push_back(row);
		row.x = 0; row.y = 0; row.z = -16384; dir_rows.push_back(row);
		row.x = 32767; row.y = 32767; row.z = 32767; dir_rows.push_back(row);
		row.x = -32768; row.y = -32768; row.z = -32768; dir_rows.push_back(row);
		row.x = -32768; row.y = 32767; row.z = 0; dir_rows.push_back(row);
		row.x = -1; row.y = 0; row.z = 0; dir_rows.push_back(row);
		row.x = -1; row.y = -1; row.z = 1; dir_rows.push_back(row);
		row.x = 1; row.y = 0; row.z = -32768; dir_rows.push_back(row);
		row.x = 32767; row.y = -32768; row.z = 32767; dir_rows.push_back(row);
		foreach (dir_rows[i])
			send_dir(dir_rows[i]);

		// write to an unused register address, then zero through a rebuilt matrix
		vec_valid <= 0;
		while (pending_dirs.size() != 0) @(posedge clk);
		apb_write(4'd12, 32'hFFFF_FFFF);
		set_angles(16'h0000, 16'h0000, 16'h0000);
		row.known = 1; row.want = zero_res;
		row.x = 0; row.y = 0; row.z = 0; send_dir(row);
		row.known = 0;
		row.x = -32768; row.y = 0; row.z = 0; send_dir(row);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = idle_plan[ph][0];
			rcv_idle = idle_plan[ph][1];
			for (int k = 0; k < 3; k++) begin
				int s;
				s = (3 * ph + k) % 8;
				if (s >= 6)
					set_angles(16'($urandom), 16'($urandom), 16'($urandom));
				else
					set_angles(sweep[s][0], sweep[s][1], sweep[s][2]);
				if (ph == 2 && k == 1)
					hold_left = 400;
				random_dirs(185);
			end
		end
		vec_valid <= 0;

		while (pending_dirs.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
